// ===== hdl/audio_sample_fifo_pair_top_assert.svh =====
// Assertion macros for the audio sample queue pair.
// Used by the top level; depends on clk and rst_n being in scope.
`ifndef AUDIO_SAMPLE_FIFO_PAIR_TOP_ASSERT_SVH
`define AUDIO_SAMPLE_FIFO_PAIR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASFP_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");
`define ASFP_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");
`else
`define ASFP_ASSERT_NOW(lbl, ant, con)
`define ASFP_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

// ===== hdl/asfp_pkg.sv =====
// Shared types and constants for the audio sample queue pair.
// No dependencies.
package asfp_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int WORD_W          = 32;

  typedef enum logic [1:0] {
    OP_PORT_RX = 2'd0,
    OP_HOST_RD = 2'd1,
    OP_HOST_WR = 2'd2,
    OP_PORT_TX = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_OVERRUN   = 3'd1,
    STAT_RD_EMPTY  = 3'd2,
    STAT_WR_FULL   = 3'd3,
    STAT_UNDERRUN  = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } asfp_cmd_t;

  typedef struct packed {
    logic out_free;
  } asfp_stat_t;

endpackage

// ===== hdl/asfp_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on asfp_pkg for the word width.
interface asfp_req_if import asfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [WORD_W-1:0] sample_in;

  modport source (output valid, output opcode, output sample_in, input ready);
  modport sink (input valid, input opcode, input sample_in, output ready);
endinterface

interface asfp_rsp_if import asfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] sample_out;
  logic [2:0]        status;

  modport source (output valid, output sample_out, output status, input ready);
  modport sink (input valid, input sample_out, input status, output ready);
endinterface

// ===== hdl/asfp_ctrl.sv =====
// Sequencing state machine: capture, execute, load result.
// Depends on asfp_pkg for the command and status structs.
module asfp_ctrl import asfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  asfp_stat_t stat,
  output asfp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== hdl/asfp_dpath.sv =====
// Ring memories, pointers, status decode and the result register.
// Depends on asfp_pkg for opcodes, status codes and command structs.
module asfp_dpath import asfp_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  asfp_cmd_t         cmd,
  output asfp_stat_t        stat,
  input  logic [1:0]        in_opcode,
  input  logic [WORD_W-1:0] in_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_sample,
  output logic [2:0]        out_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [SAMPLE_BITS-1:0] rx_mem [DEPTH];
  logic [SAMPLE_BITS-1:0] tx_mem [DEPTH];

  opcode_t                op_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [PTR_W-1:0]       rx_head_r, rx_tail_r, tx_head_r, tx_tail_r;
  logic [PTR_W-1:0]       rx_head_nxt, rx_tail_nxt, tx_head_nxt, tx_tail_nxt;
  logic [SAMPLE_BITS-1:0] rx_rd_r, tx_rd_r;
  status_t                status_r, status_nxt;
  logic                   rx_wr, tx_wr;
  logic                   out_valid_r;
  logic [WORD_W-1:0]      out_sample_r;
  status_t                out_status_r;
  logic [SAMPLE_BITS-1:0] rd_data;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= opcode_t'(in_opcode);
      smp_r <= SAMPLE_BITS'(in_sample);
    end
  end

  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    status_nxt  = STAT_OK;
    rx_wr       = 1'b0;
    tx_wr       = 1'b0;
    case (op_r)
      OP_PORT_RX: begin
        rx_wr       = 1'b1;
        rx_tail_nxt = ring_next(rx_tail_r);
        if (ring_next(rx_tail_r) == rx_head_r) begin
          rx_head_nxt = ring_next(rx_head_r);
          status_nxt  = STAT_OVERRUN;
        end
      end
      OP_HOST_RD: begin
        if (rx_head_r == rx_tail_r) begin
          status_nxt = STAT_RD_EMPTY;
        end else begin
          rx_head_nxt = ring_next(rx_head_r);
        end
      end
      OP_HOST_WR: begin
        if (ring_next(tx_tail_r) == tx_head_r) begin
          status_nxt = STAT_WR_FULL;
        end else begin
          tx_wr       = 1'b1;
          tx_tail_nxt = ring_next(tx_tail_r);
        end
      end
      OP_PORT_TX: begin
        if (tx_head_r == tx_tail_r) begin
          status_nxt = STAT_UNDERRUN;
        end else begin
          tx_head_nxt = ring_next(tx_head_r);
        end
      end
      default: status_nxt = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r <= '0;
      rx_tail_r <= '0;
      tx_head_r <= '0;
      tx_tail_r <= '0;
    end else if (cmd.exec) begin
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && rx_wr) begin
      rx_mem[rx_tail_r] <= smp_r;
    end
    if (cmd.exec) begin
      rx_rd_r <= rx_mem[rx_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && tx_wr) begin
      tx_mem[tx_tail_r] <= smp_r;
    end
    if (cmd.exec) begin
      tx_rd_r <= tx_mem[tx_head_r];
    end
  end

  assign rd_data = (op_r == OP_HOST_RD) ? rx_rd_r : tx_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      if (status_r == STAT_OK && (op_r == OP_HOST_RD || op_r == OP_PORT_TX)) begin
        out_sample_r <= WORD_W'(rd_data);
      end else begin
        out_sample_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_status    = out_status_r;

endmodule

// ===== hdl/audio_sample_fifo_pair_top.sv =====
// Top level of the audio sample queue pair: receive and transmit rings.
// Depends on asfp_pkg, asfp_if, asfp_ctrl, asfp_dpath and the assert header.
//
// Usage: in_ch carries one request word (opcode, sample_in); out_ch returns
// exactly one response word (sample_out, status) per request, in order.
// Opcodes: port sample arrives, host reads, host writes, port requests.
// A request is taken when in_ch.valid and in_ch.ready are both high.
// A request passes the capture, memory access and result load steps of the
// controller before out_ch.valid rises. The block works on one request at a
// time; a new request is taken only when those steps are done for the last
// one. The result register frees the request side: a new request
// is taken while the previous response still waits. If the receiver holds
// out_ch.ready low, the next request stops in its load step until the
// result register frees up, and in_ch.ready stays low meanwhile.
// Reset empties both rings and clears the handshake state; ring contents
// are not cleared and no clearing pass is needed.
`include "audio_sample_fifo_pair_top_assert.svh"
module audio_sample_fifo_pair_top import asfp_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  asfp_req_if.sink in_ch,
  asfp_rsp_if.source out_ch
);

  asfp_cmd_t  cmd;
  asfp_stat_t stat;
  logic       in_ready;

  asfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  asfp_dpath #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_ch.opcode),
    .in_sample  (in_ch.sample_in),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample_out),
    .out_status (out_ch.status)
  );

  assign in_ch.ready = in_ready;

  `ASFP_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASFP_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({cmd.capture, cmd.exec, cmd.load_out}))
  `ASFP_ASSERT_NOW(a_error_zero, out_ch.valid && out_ch.status != STAT_OK, out_ch.sample_out == '0)
  `ASFP_ASSERT_NEXT(a_capture_exec, cmd.capture, cmd.exec)

endmodule
